// ----- src/lrup_pkg.sv -----
// Package: shared constants and types for the LRU node pool.
`timescale 1ns / 1ps
`default_nettype none
package lrup_pkg;

  localparam int POOL_ENTRIES = 1024;
  localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int FIELD_W      = 10;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK,
    ST_SPLICE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- src/lrup_ifs.sv -----
// Interfaces: request and result channels of the LRU node pool.
`timescale 1ns / 1ps
`default_nettype none
interface lrup_req_if;
  import lrup_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [FIELD_W-1:0] entry_index;

  modport source (output valid, output opcode, output entry_index, input ready);
  modport sink   (input valid, input opcode, input entry_index, output ready);
endinterface

interface lrup_rsp_if;
  import lrup_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result_index;

  modport source (output valid, output result_index, input ready);
  modport sink   (input valid, input result_index, output ready);
endinterface
`default_nettype wire

// ----- src/lrup_link_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lrup_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/lru_node_pool.sv -----
// Top level: LRU tracker kept as a doubly linked recency list in two link RAMs.
`timescale 1ns / 1ps
`default_nettype none
// Result path: a touch of the front entry or of an index outside the pool loads the
//   output register at accept; a move reads its links, unlinks it, then splices it at front.
// Throughput: those touches take one item per cycle while the output register is free; a
//   move holds off new items until done, set by the single write port on each link RAM
//   (two next and up to two prev writes per move). Reset: after rst a clearing pass over
//   all POOL_ENTRIES entries rebuilds the 0..N-1 order in the link RAMs; req.ready stays low meanwhile.
// Output register: a new item is taken while a result still waits on rsp.
module lru_node_pool (
  input  wire logic clk,
  input  wire logic rst,
  lrup_req_if.sink  req,
  lrup_rsp_if.source rsp
);
  import lrup_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

  state_t state, state_next;

  // list ends and the entry being moved
  logic [IDX_W-1:0] front, back, node;
  logic [IDX_W-1:0] clr_cnt;

  // output register
  logic               out_valid;
  logic [FIELD_W-1:0] out_index;

  // link RAM ports
  logic             nx_we, pv_we, rd_en;
  logic [IDX_W-1:0] nx_waddr, pv_waddr, rd_addr;
  logic [IDX_W-1:0] nx_wdata, pv_wdata;
  logic [IDX_W-1:0] nx_rdata, pv_rdata;

  // request decode
  logic             accept, in_range, fast, out_free, load_out;
  logic [IDX_W-1:0] cand, res_value;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    if (req.opcode == OP_ALLOC) begin
      cand     = back;
      in_range = 1'b1;
    end else begin
      cand     = IDX_W'(req.entry_index);
      in_range = (32'(req.entry_index) < 32'(POOL_ENTRIES));
    end
    // nothing moves for the front entry or an out-of-pool index
    fast = !in_range || (cand == front);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!fast)         state_next = ST_LINK;
          else if (!out_free) state_next = ST_DONE;
        end
      end
      ST_LINK:   state_next = ST_SPLICE;
      ST_SPLICE: state_next = out_free ? ST_IDLE : ST_DONE;
      ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------- outputs / RAM control ----------------
  always_comb begin
    req.ready = 1'b0;
    nx_we     = 1'b0;
    pv_we     = 1'b0;
    nx_waddr  = '0;
    pv_waddr  = '0;
    nx_wdata  = '0;
    pv_wdata  = '0;
    rd_en     = 1'b0;
    rd_addr   = cand;
    load_out  = 1'b0;
    res_value = node;
    case (state)
      ST_CLEAR: begin
        // entry i: next = i+1 (last wraps to 0), prev = i-1 (entry 0 keeps 0)
        nx_we    = 1'b1;
        nx_waddr = clr_cnt;
        nx_wdata = (clr_cnt == LAST_IDX) ? '0 : IDX_W'(clr_cnt + 1'b1);
        pv_we    = 1'b1;
        pv_waddr = clr_cnt;
        pv_wdata = (clr_cnt == '0) ? '0 : IDX_W'(clr_cnt - 1'b1);
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        rd_en     = accept && !fast;
        load_out  = accept && fast && out_free;
        res_value = front;
      end
      ST_LINK: begin
        // unlink: next[before] = after; prev[after] = before unless node is back
        nx_we    = 1'b1;
        nx_waddr = pv_rdata;
        nx_wdata = nx_rdata;
        pv_we    = (node != back);
        pv_waddr = nx_rdata;
        pv_wdata = pv_rdata;
      end
      ST_SPLICE: begin
        // splice at front: next[node] = front; prev[front] = node
        nx_we    = 1'b1;
        nx_waddr = node;
        nx_wdata = front;
        pv_we    = 1'b1;
        pv_waddr = front;
        pv_wdata = node;
        load_out = out_free;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      front   <= '0;
      back    <= LAST_IDX;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= IDX_W'(clr_cnt + 1'b1);
      if (state == ST_LINK && node == back) back <= pv_rdata;
      if (state == ST_SPLICE) front <= node;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      node <= fast ? front : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index <= FIELD_W'(res_value);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_index = out_index;

  // ---------------- link memories ----------------
  lrup_link_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(IDX_W)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (nx_rdata)
  );

  lrup_link_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(IDX_W)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pv_rdata)
  );

endmodule
`default_nettype wire
